### rtl/core/mrfp_pkg.sv
// Shared types and constants of the motor reply frame parser.
// Holds the frame markers, status codes and the event record passed from front to back.
// No dependencies.
package mrfp_pkg;

	// Longest accepted frame length plus one; lengths of 1 to MAX_FRAME-1 are taken.
	localparam int MAX_FRAME = 32;
	localparam int FLEN_W    = $clog2(MAX_FRAME);

	// Depth of the event queue between the front and the back.
	localparam int FIFO_DEPTH = 2;
	localparam int QPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int QCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
	localparam logic [7:0] OWN_ADDR_RST   = 8'h01;
	localparam logic [7:0] END_MARK       = 8'h6B;
	localparam logic [7:0] CMD_SPEED      = 8'h35;
	localparam logic [7:0] CMD_POSITION   = 8'h36;
	localparam logic [7:0] CMD_FLAGS      = 8'h3A;

	// Minimum frame lengths (command, payload and end byte) for each command.
	localparam int MIN_LEN_SPEED    = 4;
	localparam int MIN_LEN_POSITION = 6;
	localparam int MIN_LEN_FLAGS    = 3;

	localparam logic [2:0] ST_SPEED    = 3'd0;
	localparam logic [2:0] ST_POSITION = 3'd1;
	localparam logic [2:0] ST_FLAGS    = 3'd2;
	localparam logic [2:0] ST_IGNORED  = 3'd3;
	localparam logic [2:0] ST_BAD_END  = 3'd4;
	localparam logic [2:0] ST_BAD_LEN  = 3'd5;

	// One finished or aborted frame, as handed from the front to the back.
	typedef struct packed {
		logic              bad_len;
		logic [7:0]        cmd;
		logic [31:0]       payload;
		logic [7:0]        last_byte;
		logic [FLEN_W-1:0] flen;
	} evt_t;

endpackage

### rtl/core/mrfp_ifs.sv
// Channel interfaces of the motor reply frame parser: received bytes, results, configuration.
// Each carries valid, ready and the payload, with source and sink modports.
// No dependencies.
interface mrfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrfp_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         frame_status;
	logic signed [15:0] speed;
	logic signed [31:0] position;
	logic               enabled;
	logic               moving;
	logic               fault;
	modport source (output valid, output frame_status, output speed, output position,
		output enabled, output moving, output fault, input ready);
	modport sink   (input valid, input frame_status, input speed, input position,
		input enabled, input moving, input fault, output ready);
endinterface

interface mrfp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] own_address;
	modport source (output valid, output own_address, input ready);
	modport sink   (input valid, input own_address, output ready);
endinterface

### rtl/core/mrfp_front.sv
// Front of the motor reply frame parser: takes bytes and tracks the frame.
// Emits one event per finished or aborted frame into the queue.
// Depends on mrfp_pkg.
module mrfp_front import mrfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] own_addr,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       push,
	output evt_t       evt
);

	typedef enum logic [1:0] {PH_ADDR, PH_LEN, PH_DATA} phase_t;

	phase_t            phase_q, phase_nxt;
	logic [FLEN_W-1:0] cnt_q, cnt_nxt, cnt_inc;
	logic [FLEN_W-1:0] len_q, len_nxt;
	logic [7:0]        cmd_q, cmd_nxt;
	logic [31:0]       pay_q, pay_nxt;
	logic [7:0]        last_q, last_nxt;
	logic              accept, len_ok, emit;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign len_ok   = (in_byte != 8'd0) && (32'(in_byte) < 32'(MAX_FRAME));
	assign cnt_inc  = cnt_q + FLEN_W'(1);

	always_comb begin
		phase_nxt = phase_q;
		cnt_nxt   = cnt_q;
		len_nxt   = len_q;
		cmd_nxt   = cmd_q;
		pay_nxt   = pay_q;
		last_nxt  = last_q;
		emit      = 1'b0;
		evt       = '0;
		case (phase_q)
			PH_LEN: begin
				if (len_ok) begin
					len_nxt   = in_byte[FLEN_W-1:0];
					cnt_nxt   = '0;
					cmd_nxt   = '0;
					pay_nxt   = '0;
					phase_nxt = PH_DATA;
				end else begin
					emit      = 1'b1;
					phase_nxt = PH_ADDR;
				end
				evt.bad_len = 1'b1;
			end
			PH_DATA: begin
				case (cnt_q)
					FLEN_W'(0): cmd_nxt         = in_byte;
					FLEN_W'(1): pay_nxt[31:24]  = in_byte;
					FLEN_W'(2): pay_nxt[23:16]  = in_byte;
					FLEN_W'(3): pay_nxt[15:8]   = in_byte;
					FLEN_W'(4): pay_nxt[7:0]    = in_byte;
					default:    pay_nxt         = pay_q;
				endcase
				cnt_nxt  = cnt_inc;
				last_nxt = in_byte;
				if (cnt_inc >= len_q) begin
					emit      = 1'b1;
					phase_nxt = PH_ADDR;
				end
			end
			default: begin
				// Hunting: only our own address or broadcast opens a frame.
				if (in_byte == own_addr || in_byte == BROADCAST_ADDR) begin
					phase_nxt = PH_LEN;
				end else begin
					phase_nxt = PH_ADDR;
				end
			end
		endcase
		evt.cmd       = cmd_nxt;
		evt.payload   = pay_nxt;
		evt.last_byte = last_nxt;
		evt.flen      = len_q;
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR;
			cnt_q   <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
			pay_q   <= '0;
			last_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			cnt_q   <= cnt_nxt;
			len_q   <= len_nxt;
			cmd_q   <= cmd_nxt;
			pay_q   <= pay_nxt;
			last_q  <= last_nxt;
		end
	end

endmodule

### rtl/core/mrfp_evt_fifo.sv
// Short event queue between the front and the back of the frame parser.
// Holds FIFO_DEPTH frame events so either side can stall on its own.
// Depends on mrfp_pkg.
module mrfp_evt_fifo import mrfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  evt_t push_evt,
	output logic full,
	input  logic pop,
	output evt_t head,
	output logic empty
);

	evt_t              mem_q [FIFO_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(FIFO_DEPTH))
		else $error("event queue count exceeds its depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("front pushed into a full event queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("back popped an empty event queue");

endmodule

### rtl/core/mrfp_back.sv
// Back of the frame parser: judges each frame event and updates the motor state.
// Drives the registered result with its status and the current state.
// Depends on mrfp_pkg.
module mrfp_back import mrfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  evt_t               head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [2:0]         status,
	output logic signed [15:0] speed,
	output logic signed [31:0] position,
	output logic [2:0]         flags
);

	logic               valid_q;
	logic [2:0]         status_q, status_nxt;
	logic signed [15:0] speed_q, speed_nxt;
	logic signed [31:0] pos_q, pos_nxt;
	logic [2:0]         flags_q, flags_nxt;

	assign pop = !q_empty && (!valid_q || res_ready);

	always_comb begin
		status_nxt = ST_IGNORED;
		speed_nxt  = speed_q;
		pos_nxt    = pos_q;
		flags_nxt  = flags_q;
		if (head.bad_len) begin
			status_nxt = ST_BAD_LEN;
		end else if (head.last_byte != END_MARK) begin
			status_nxt = ST_BAD_END;
		end else if (head.cmd == CMD_SPEED) begin
			if (32'(head.flen) >= 32'(MIN_LEN_SPEED)) begin
				speed_nxt  = head.payload[31:16];
				status_nxt = ST_SPEED;
			end
		end else if (head.cmd == CMD_POSITION) begin
			if (32'(head.flen) >= 32'(MIN_LEN_POSITION)) begin
				pos_nxt    = head.payload;
				status_nxt = ST_POSITION;
			end
		end else if (head.cmd == CMD_FLAGS) begin
			if (32'(head.flen) >= 32'(MIN_LEN_FLAGS)) begin
				flags_nxt  = head.payload[26:24];
				status_nxt = ST_FLAGS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			status_q <= ST_IGNORED;
			speed_q  <= '0;
			pos_q    <= '0;
			flags_q  <= '0;
		end else if (pop) begin
			valid_q  <= 1'b1;
			status_q <= status_nxt;
			speed_q  <= speed_nxt;
			pos_q    <= pos_nxt;
			flags_q  <= flags_nxt;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign res_valid = valid_q;
	assign status    = status_q;
	assign speed     = speed_q;
	assign position  = pos_q;
	assign flags     = flags_q;

endmodule

### rtl/core/motor_reply_frame_parser_unit.sv
// Top level of the motor reply frame parser.
// Ties the front, the event queue and the back together and holds the address register.
// Depends on mrfp_pkg, mrfp_ifs, mrfp_front, mrfp_evt_fifo and mrfp_back.
//
// The rx channel brings one received byte per beat from the stepper driver link. The
// parser hunts for a frame start equal to own_address or broadcast 0xFF, takes a length
// byte and then that many data bytes, the last of which must be 0x6B. The res channel
// gives one beat for each finished or aborted frame: its status code and the current
// speed, position and flag state after the frame was handled. Bytes that open no frame
// or fall inside one give no beat.
// The cfg channel writes own_address; it is always ready and should be used only while
// the parser is idle.
// Throughput is one byte per cycle while the event queue has space. The byte that
// ends a frame puts its event into a two-entry queue when it is accepted, and the
// result register loads that event once it is empty or its beat is being taken.
// When res is stalled the result register holds its beat and further frame events wait
// in the queue; rx drops ready only once the queue is full, and bytes that end no frame
// still wait for queue space then.
// Reset clears the parser to hunting, the motor state to zero and own_address to 1.
module motor_reply_frame_parser_unit import mrfp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mrfp_byte_if.sink     rx,
	mrfp_result_if.source res,
	mrfp_cfg_if.sink      cfg
);

	logic [7:0] own_addr_q;
	logic       push, pop, q_full, q_empty;
	evt_t       push_evt, head_evt;
	logic [2:0] flags;

	// The address register takes every write beat at once.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= OWN_ADDR_RST;
		end else if (cfg.valid) begin
			own_addr_q <= cfg.own_address;
		end
	end

	// Front: frame tracking, one event per finished or aborted frame.
	mrfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.own_addr (own_addr_q),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.in_byte  (rx.rx_byte),
		.q_full   (q_full),
		.push     (push),
		.evt      (push_evt)
	);

	// Queue that decouples frame tracking from the result side.
	mrfp_evt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_evt (push_evt),
		.full     (q_full),
		.pop      (pop),
		.head     (head_evt),
		.empty    (q_empty)
	);

	// Back: frame checks, motor state update and the result register.
	mrfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head_evt),
		.pop       (pop),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.status    (res.frame_status),
		.speed     (res.speed),
		.position  (res.position),
		.flags     (flags)
	);

	// Flag bits 0, 1 and 2 of the status reply.
	assign res.enabled = flags[0];
	assign res.moving  = flags[1];
	assign res.fault   = flags[2];

endmodule
